/* hdl/jlsd_pkg.sv */
package jlsd_pkg;

  // Field widths
  localparam int unsigned NumJoints = 3;
  localparam int unsigned AngW      = 20;
  localparam int unsigned ErrW      = 20;
  localparam int unsigned LimW      = 19;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 19;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_COLLISION = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_STEP = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ARM_STEP  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HOLD      = 3'd3;

  // Register reset values
  localparam logic [LimW-1:0]  RST_COLLISION = 19'd10000;
  localparam logic [LimW-1:0]  RST_BASE_STEP = 19'd4000;
  localparam logic [LimW-1:0]  RST_ARM_STEP  = 19'd1500;
  localparam logic [HoldW-1:0] RST_HOLD      = 16'd1000;

  // Reported fault phase codes
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_LATCHED = 2'd1;
  localparam logic [1:0] PHASE_HOLD    = 2'd2;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_HOLD = 2'b10
  } fsm_e;

  typedef struct packed {
    logic                   detect_enable;
    logic [2:0]             limit_alarms;
    logic                   other_alarm;
    logic [TimeW-1:0]       now_ms;
    logic signed [AngW-1:0] measured_a;
    logic signed [AngW-1:0] measured_b;
    logic signed [AngW-1:0] measured_c;
    logic signed [AngW-1:0] commanded_a;
    logic signed [AngW-1:0] commanded_b;
    logic signed [AngW-1:0] commanded_c;
  } in_item_t;

  typedef struct packed {
    logic       stop_request;
    logic [2:0] fault_axes;
    logic       pose_resync;
    logic [1:0] fault_phase;
  } out_item_t;

  // Sample-wide fields held alongside the lane errors
  typedef struct packed {
    logic             detect_enable;
    logic [2:0]       limit_alarms;
    logic             other_alarm;
    logic [TimeW-1:0] now_ms;
  } ctl_t;

  // What one lane reports to the merge stage
  typedef struct packed {
    logic entry;
    logic hit;
  } lane_stat_t;

  function automatic logic [1:0] phase_code(fsm_e st);
    logic [1:0] code;
    unique case (st)
      FSM_IDLE: code = PHASE_IDLE;
      FSM_HOLD: code = PHASE_HOLD;
      default:  code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

/* hdl/jlsd_lane.sv */
module jlsd_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic signed [jlsd_pkg::AngW-1:0] measured_i,
  input  logic signed [jlsd_pkg::AngW-1:0] commanded_i,
  input  logic                            update_i,
  input  logic                            tracking_i,
  input  logic [jlsd_pkg::LimW-1:0]       thr_i,
  input  logic [jlsd_pkg::LimW-1:0]       coll_i,
  output jlsd_pkg::lane_stat_t            stat_o
);
  import jlsd_pkg::*;

  logic [AngW:0]   diff;
  logic [AngW:0]   mag;
  logic [ErrW-1:0] err_d, err_q;
  logic [ErrW-1:0] last_q;
  logic [ErrW-1:0] chg;
  logic [ErrW-1:0] thr_ext;
  logic [ErrW-1:0] coll_ext;
  logic            step_hit;

  // Stage 1: absolute following error; 20-bit operands keep it within 20 bits
  assign diff  = {measured_i[AngW-1], measured_i} - {commanded_i[AngW-1], commanded_i};
  assign mag   = diff[AngW] ? (~diff + 1'b1) : diff;
  assign err_d = mag[ErrW-1:0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_q <= err_d;
    end
  end

  // Previous processed error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (update_i) begin
      last_q <= err_q;
    end
  end

  // Stage 2: change since last sample and threshold checks
  assign chg      = (err_q >= last_q) ? (err_q - last_q) : (last_q - err_q);
  assign thr_ext  = {1'b0, thr_i};
  assign coll_ext = {1'b0, coll_i};
  // Change counts as zero until tracking, so a zero threshold still trips
  assign step_hit = tracking_i ? (chg >= thr_ext) : (thr_i == '0);

  assign stat_o.entry = (err_q >= thr_ext);
  assign stat_o.hit   = (err_q > coll_ext) || step_hit;

endmodule

/* hdl/jlsd_ctrl.sv */
module jlsd_ctrl (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   go_i,
  input  jlsd_pkg::ctl_t                         ctl_i,
  input  jlsd_pkg::lane_stat_t [jlsd_pkg::NumJoints-1:0] stat_i,
  input  logic [jlsd_pkg::HoldW-1:0]             hold_i,
  output logic                                   tracking_o,
  output logic                                   update_o,
  output jlsd_pkg::out_item_t                    res_o
);
  import jlsd_pkg::*;

  fsm_e             fsm_d, fsm_q;
  logic             tracking_d, tracking_q;
  logic [TimeW-1:0] ft_d, ft_q;
  logic             suspended;
  logic             armed;
  logic [2:0]       axes;
  logic             stop;
  logic             any_entry;
  logic [TimeW-1:0] elapsed;
  logic             expire;
  logic             process;

  assign suspended = !ctl_i.detect_enable || (ctl_i.limit_alarms != '0);
  assign process   = go_i && !suspended;
  assign update_o  = process;
  assign tracking_o = tracking_q;

  // Merge lane findings
  assign armed     = !suspended && !ctl_i.other_alarm && (fsm_q == FSM_IDLE);
  assign axes      = armed ? {stat_i[2].hit, stat_i[1].hit, stat_i[0].hit} : 3'b000;
  assign stop      = (axes != 3'b000);
  assign any_entry = stat_i[0].entry || stat_i[1].entry || stat_i[2].entry;

  // Hold timer: a fault latched now has zero elapsed time
  assign elapsed = ctl_i.now_ms - ft_q;
  assign expire  = stop ? (hold_i == '0)
                        : ((fsm_q == FSM_HOLD) && (elapsed >= {16'b0, hold_i}));

  // Next state
  always_comb begin
    fsm_d      = fsm_q;
    tracking_d = tracking_q;
    ft_d       = ft_q;
    if (process) begin
      tracking_d = tracking_q || any_entry;
      if (stop) begin
        ft_d  = ctl_i.now_ms;
        fsm_d = FSM_HOLD;
      end
      if (expire) begin
        tracking_d = 1'b0;
        fsm_d      = FSM_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q      <= FSM_IDLE;
      tracking_q <= 1'b0;
      ft_q       <= '0;
    end else begin
      fsm_q      <= fsm_d;
      tracking_q <= tracking_d;
      ft_q       <= ft_d;
    end
  end

  // Result of the sample
  always_comb begin
    res_o.stop_request = stop;
    res_o.fault_axes   = axes;
    res_o.pose_resync  = !suspended && expire;
    if (suspended) begin
      res_o.fault_phase = phase_code(fsm_q);
    end else if (stop) begin
      res_o.fault_phase = PHASE_LATCHED;
    end else if (expire) begin
      res_o.fault_phase = PHASE_IDLE;
    end else begin
      res_o.fault_phase = phase_code(fsm_q);
    end
  end

  a_stop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && stop && (hold_i != '0) |=> (fsm_q == FSM_HOLD) && (ft_q == $past(ctl_i.now_ms)))
    else $error("fault not latched into hold");

  a_resync_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && res_o.pose_resync |=> !tracking_q && (fsm_q == FSM_IDLE))
    else $error("resync without re-arm");

  a_suspend_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && suspended |=> $stable(fsm_q) && $stable(tracking_q) && $stable(ft_q))
    else $error("state moved on a suspended sample");

  a_no_fault_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == FSM_HOLD) |-> !stop)
    else $error("new fault during hold");

endmodule

/* hdl/jlsd_out_buf.sv */
module jlsd_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jlsd_pkg::out_item_t data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jlsd_pkg::out_item_t out_data_o
);
  import jlsd_pkg::*;

  out_item_t  ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = ent_q[rd_ptr_q];

  // Two-entry result queue
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* hdl/joint_lost_step_detector_top.sv */
// Joint lost-step detector.
// Input channel in_valid_i/in_ready_o carries one sample (enable, alarms,
// timestamp, measured and commanded angles of three joints). Output channel
// out_valid_o/out_ready_i returns exactly one result per sample, in order.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 collision limit, 1 base step limit, 2 arm step limit, 3 hold time);
// other indexes are dropped. Write only while no sample is in flight.
// Flow: the error lanes register the sample, then the change/merge stage,
// which also owns the fault phase and hold timer, writes the result queue
// that drives out_valid_o.
// Throughput: one sample per cycle while the result queue has room or the
// receiver takes a result; the state loop is closed within the merge stage.
// A two-entry result queue sits at the output; when the receiver stalls it
// fills, then the merge stage holds its sample and in_ready_o drops in the
// same cycle, rising again in the cycle the receiver takes a result.
// Reset: registers return to their reset values, tracking and the fault
// phase clear, saved errors and the fault time return to zero.
module joint_lost_step_detector_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  jlsd_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output jlsd_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [jlsd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [jlsd_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import jlsd_pkg::*;

  logic [LimW-1:0]  coll_q, base_q, arm_q;
  logic [HoldW-1:0] hold_q;
  logic             s1_valid_q;
  ctl_t             ctl_q;
  logic             load;
  logic             go;
  logic             full;
  logic             tracking;
  logic             update;
  out_item_t        res;
  lane_stat_t [NumJoints-1:0] stat;
  logic signed [AngW-1:0] meas [NumJoints];
  logic signed [AngW-1:0] cmd  [NumJoints];
  logic [LimW-1:0]  thr  [NumJoints];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q <= RST_COLLISION;
      base_q <= RST_BASE_STEP;
      arm_q  <= RST_ARM_STEP;
      hold_q <= RST_HOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLLISION: coll_q <= cfg_wdata_i;
        CFG_BASE_STEP: base_q <= cfg_wdata_i;
        CFG_ARM_STEP:  arm_q  <= cfg_wdata_i;
        CFG_HOLD:      hold_q <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake
  assign go         = s1_valid_q && (!full || out_ready_i);
  assign in_ready_o = !s1_valid_q || go;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (load) begin
      s1_valid_q <= 1'b1;
    end else if (go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctl_q.detect_enable <= in_data_i.detect_enable;
      ctl_q.limit_alarms  <= in_data_i.limit_alarms;
      ctl_q.other_alarm   <= in_data_i.other_alarm;
      ctl_q.now_ms        <= in_data_i.now_ms;
    end
  end

  // Per-joint lanes
  assign meas[0] = in_data_i.measured_a;
  assign meas[1] = in_data_i.measured_b;
  assign meas[2] = in_data_i.measured_c;
  assign cmd[0]  = in_data_i.commanded_a;
  assign cmd[1]  = in_data_i.commanded_b;
  assign cmd[2]  = in_data_i.commanded_c;
  assign thr[0]  = base_q;
  assign thr[1]  = arm_q;
  assign thr[2]  = arm_q;

  for (genvar j = 0; j < NumJoints; j++) begin : g_lane
    jlsd_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .measured_i  (meas[j]),
      .commanded_i (cmd[j]),
      .update_i    (update),
      .tracking_i  (tracking),
      .thr_i       (thr[j]),
      .coll_i      (coll_q),
      .stat_o      (stat[j])
    );
  end

  // Merge, fault phase and hold timer
  jlsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .ctl_i      (ctl_q),
    .stat_i     (stat),
    .hold_i     (hold_q),
    .tracking_o (tracking),
    .update_o   (update),
    .res_o      (res)
  );

  // Result queue
  jlsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (go),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
